>>> src/pwsr_pkg.sv
// Shared types and field widths for the page window slot reserver.
package pwsr_pkg;

   localparam int ADDR_W        = 64;
   localparam int SIZE_W        = 64;
   localparam int SLOT_FIELD_W  = 4;
   localparam int OFFSET_W      = 12;
   localparam int COUNT_FIELD_W = 5;

   typedef enum logic {
      OP_RESERVE = 1'b0,
      OP_CLEAR   = 1'b1
   } op_type;

   typedef struct packed {
      op_type              operation;
      logic [ADDR_W-1:0]   physical_address;
      logic [SIZE_W-1:0]   size_bytes;
   } req_type;

   typedef struct packed {
      logic                     success;
      logic [SLOT_FIELD_W-1:0]  head_slot;
      logic [OFFSET_W-1:0]      byte_offset;
      logic [SLOT_FIELD_W-1:0]  fresh_slot;
      logic [COUNT_FIELD_W-1:0] fresh_count;
   } rsp_type;

endpackage

>>> src/page_window_slot_reserver_unit.sv
// Page window slot reserver: sequential run search over a slot RAM, top level.
// Sequence: clear goes straight to the response; reserve runs the checks (CHK1, CHK2), then
//   scan steps (run start tried, switch to prefix search, final decision), a RAM read and
//   compare per slot comparison, a write per slot written, then the response.
// Throughput: one request at a time; the next is taken once the response is taken.
// Reset: used count cleared, slot contents left undefined (no clearing pass).
module page_window_slot_reserver_unit #(
   parameter int SLOT_COUNT = 16,
   parameter int PAGE_BYTES = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pwsr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pwsr_pkg::rsp_type rsp_data
);

   import pwsr_pkg::*;

   localparam int SW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CW  = $clog2(SLOT_COUNT + 1);
   localparam int OB  = $clog2(PAGE_BYTES);
   localparam int PNW = ADDR_W - OB;
   localparam logic [CW-1:0] SLOTS = CW'(SLOT_COUNT);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_CHK1  = 8'b00000010,
      ST_CHK2  = 8'b00000100,
      ST_SCAN  = 8'b00001000,
      ST_RD    = 8'b00010000,
      ST_CMP   = 8'b00100000,
      ST_WRITE = 8'b01000000,
      ST_DONE  = 8'b10000000
   } state_type;

   state_type         state_ff, state_in;
   logic              prefix_ff, prefix_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic              bad_ff, bad_in;
   logic [SIZE_W-1:0] span_ff, span_in;
   logic [CW-1:0]     pages_ff, pages_in;
   logic [CW-1:0]     used_ff, used_in;
   logic [CW-1:0]     start_ff, start_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     left_ff, left_in;
   logic [PNW-1:0]    exp_ff, exp_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [SIZE_W:0]   sum_end;
   logic [SIZE_W:0]   sum_span;
   logic [PNW:0]      count;
   logic [CW-1:0]     run_len;
   logic [CW-1:0]     room;
   logic [CW-1:0]     missing;
   logic [PNW-1:0]    base;
   logic [OFFSET_W-1:0] offset;
   logic              ram_we;
   logic [SW-1:0]     ram_wr_addr;
   logic [SW-1:0]     ram_rd_addr;
   logic [PNW-1:0]    ram_rd_data;

   pwsr_ram #(
      .WIDTH (PNW),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (exp_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      prefix_in    = prefix_ff;
      addr_in      = addr_ff;
      size_in      = size_ff;
      bad_in       = bad_ff;
      span_in      = span_ff;
      pages_in     = pages_ff;
      used_in      = used_ff;
      start_in     = start_ff;
      idx_in       = idx_ff;
      left_in      = left_ff;
      exp_in       = exp_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_we       = 1'b0;

      sum_end     = {1'b0, addr_ff} + {1'b0, size_ff};
      sum_span    = {1'b0, size_ff} + (SIZE_W + 1)'(addr_ff[OB-1:0]);
      count       = (PNW + 1)'(span_ff[SIZE_W-1:OB]) + (PNW + 1)'(|span_ff[OB-1:0]);
      run_len     = prefix_ff ? used_ff - start_ff : pages_ff;
      room        = SLOTS - used_ff;
      missing     = pages_ff - run_len;
      base        = addr_ff[ADDR_W-1:OB];
      offset      = OFFSET_W'(addr_ff[OB-1:0]);
      ram_wr_addr = SW'(used_ff);
      ram_rd_addr = SW'(start_ff + idx_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               addr_in = req_data.physical_address;
               size_in = req_data.size_bytes;
               if (req_data.operation == OP_CLEAR) begin
                  used_in        = '0;
                  rsp_in         = '0;
                  rsp_in.success = 1'b1;
                  rsp_valid_in   = 1'b1;
                  state_in       = ST_DONE;
               end else begin
                  state_in = ST_CHK1;
               end
            end
         end
         ST_CHK1: begin
            bad_in   = (size_ff == '0) || (sum_end[SIZE_W] && (sum_end[SIZE_W-1:0] != '0))
                       || sum_span[SIZE_W];
            span_in  = sum_span[SIZE_W-1:0];
            state_in = ST_CHK2;
         end
         ST_CHK2: begin
            if (bad_ff || (count > (PNW + 1)'(SLOT_COUNT))) begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_DONE;
            end else begin
               pages_in  = CW'(count);
               prefix_in = 1'b0;
               start_in  = '0;
               idx_in    = '0;
               exp_in    = base;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!prefix_ff) begin
               if (({1'b0, start_ff} + {1'b0, pages_ff}) <= {1'b0, used_ff}) begin
                  state_in = ST_RD;
               end else begin
                  prefix_in = 1'b1;
                  start_in  = (used_ff >= pages_ff) ? used_ff - pages_ff + 1'b1 : '0;
               end
            end else if (start_ff < used_ff) begin
               state_in = ST_RD;
            end else if (pages_ff > room) begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_DONE;
            end else begin
               // whole sequence appended after the used slots
               rsp_in.success     = 1'b1;
               rsp_in.head_slot   = SLOT_FIELD_W'(used_ff);
               rsp_in.byte_offset = offset;
               rsp_in.fresh_slot  = SLOT_FIELD_W'(used_ff);
               rsp_in.fresh_count = COUNT_FIELD_W'(pages_ff);
               left_in            = pages_ff;
               exp_in             = base;
               state_in           = ST_WRITE;
            end
         end
         ST_RD: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (ram_rd_data != exp_ff) begin
               start_in = start_ff + 1'b1;
               idx_in   = '0;
               exp_in   = base;
               state_in = ST_SCAN;
            end else if ((idx_ff + 1'b1) == run_len) begin
               if (!prefix_ff) begin
                  rsp_in             = '0;
                  rsp_in.success     = 1'b1;
                  rsp_in.head_slot   = SLOT_FIELD_W'(start_ff);
                  rsp_in.byte_offset = offset;
                  rsp_valid_in       = 1'b1;
                  state_in           = ST_DONE;
               end else if (missing > room) begin
                  rsp_in       = '0;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_DONE;
               end else begin
                  rsp_in.success     = 1'b1;
                  rsp_in.head_slot   = SLOT_FIELD_W'(start_ff);
                  rsp_in.byte_offset = offset;
                  rsp_in.fresh_slot  = SLOT_FIELD_W'(used_ff);
                  rsp_in.fresh_count = COUNT_FIELD_W'(missing);
                  left_in            = missing;
                  exp_in             = exp_ff + 1'b1;
                  state_in           = ST_WRITE;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               exp_in   = exp_ff + 1'b1;
               state_in = ST_RD;
            end
         end
         ST_WRITE: begin
            ram_we  = 1'b1;
            used_in = used_ff + 1'b1;
            exp_in  = exp_ff + 1'b1;
            left_in = left_ff - 1'b1;
            if (left_ff == CW'(1)) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prefix_ff <= prefix_in;
      addr_ff   <= addr_in;
      size_ff   <= size_in;
      bad_ff    <= bad_in;
      span_ff   <= span_in;
      pages_ff  <= pages_in;
      start_ff  <= start_in;
      idx_ff    <= idx_in;
      left_ff   <= left_in;
      exp_ff    <= exp_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= SLOTS)
      else $error("used count beyond slot count");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (used_ff < SLOTS))
      else $error("slot write past end of window");

   a_valid_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff == (state_ff == ST_DONE))
      else $error("response valid out of step with sequencer");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("request accepted but sequencer idle");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.success) |-> (rsp_data == '0))
      else $error("rejected request with non-zero fields");

endmodule

>>> src/pwsr_ram.sv
// Generic single write port, single registered read port RAM.
module pwsr_ram #(
   parameter int WIDTH = 52,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sim/page_window_slot_reserver_unit_test.sv
// Self-checking testbench for the page window slot reserver: queued driver, scoreboard monitor.
`timescale 1ns / 1ps

module page_window_slot_reserver_unit_test;
   import pwsr_pkg::*;

   localparam int SLOTS        = 16;
   localparam int SETTLE_TICKS = 1000;
   localparam int RANDOM_ITEMS = 1300;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   page_window_slot_reserver_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the slot window
   logic [51:0] window_page [SLOTS];
   int          window_fill = 0;

   req_type request_backlog [$];
   rsp_type pending_grants  [$];
   int      error_count = 0;

   function automatic bit run_holds(int start, int len, logic [51:0] base);
      for (int i = 0; i < len; i++) begin
         if (window_page[start + i] != base + 52'(i)) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic rsp_type grant_outcome(req_type r);
      rsp_type     res;
      logic [64:0] tail_sum;
      logic [64:0] span;
      logic [52:0] page_total;
      logic [11:0] offs;
      logic [51:0] base;
      int          pages;
      int          avail;
      int          missing;
      int          first_new;
      res = '0;
      if (r.operation == OP_CLEAR) begin
         window_fill = 0;
         res.success = 1'b1;
         return res;
      end
      if (r.size_bytes == 64'd0) return res;
      tail_sum = {1'b0, r.physical_address} + {1'b0, r.size_bytes} - 65'd1;
      if (tail_sum[64]) return res;
      offs = r.physical_address[11:0];
      span = {1'b0, r.size_bytes} + 65'(offs);
      if (span[64]) return res;
      page_total = {1'b0, span[63:12]} + 53'(span[11:0] != 12'd0);
      if (page_total > 53'(SLOTS)) return res;
      pages = int'(page_total);
      base  = r.physical_address[63:12];

      for (int s = 0; s + pages <= window_fill; s++) begin
         if (run_holds(s, pages, base)) begin
            res.success     = 1'b1;
            res.head_slot   = 4'(s);
            res.byte_offset = offs;
            return res;
         end
      end

      for (int s = 0; s < window_fill; s++) begin
         avail = window_fill - s;
         if (avail >= pages) continue;
         if (!run_holds(s, avail, base)) continue;
         missing = pages - avail;
         if (missing > SLOTS - window_fill) return res;
         first_new = window_fill;
         for (int i = avail; i < pages; i++) begin
            window_page[window_fill] = base + 52'(i);
            window_fill++;
         end
         res.success     = 1'b1;
         res.head_slot   = 4'(s);
         res.byte_offset = offs;
         res.fresh_slot  = 4'(first_new);
         res.fresh_count = 5'(missing);
         return res;
      end

      if (pages > SLOTS - window_fill) return res;
      first_new = window_fill;
      for (int i = 0; i < pages; i++) window_page[first_new + i] = base + 52'(i);
      window_fill     = window_fill + pages;
      res.success     = 1'b1;
      res.head_slot   = 4'(first_new);
      res.byte_offset = offs;
      res.fresh_slot  = 4'(first_new);
      res.fresh_count = 5'(pages);
      return res;
   endfunction

   // driver: bursts of requests with random gaps
   int burst_left = 4;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) pending_grants.push_back(grant_outcome(req_data));
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 || request_backlog.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               req_data  <= request_backlog.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
               end
            end
         end
      end
   end

   task automatic compare_field(input string label, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t %s mismatch: expected %0h actual %0h", $time, label, want, got);
      end
   endtask

   // monitor: scoreboard plus stall pattern
   int      calm_left = 0;
   int      hold_left = 0;
   rsp_type want;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_grants.size() == 0) begin
               error_count++;
               $display("%0t response with no request outstanding: expected none actual %0h",
                        $time, rsp_data);
            end else begin
               want = pending_grants.pop_front();
               compare_field("success", 16'(want.success), 16'(rsp_data.success));
               compare_field("head_slot", 16'(want.head_slot), 16'(rsp_data.head_slot));
               compare_field("byte_offset", 16'(want.byte_offset),
                             16'(rsp_data.byte_offset));
               compare_field("fresh_slot", 16'(want.fresh_slot),
                             16'(rsp_data.fresh_slot));
               compare_field("fresh_count", 16'(want.fresh_count),
                             16'(rsp_data.fresh_count));
            end
         end
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (calm_left > 0) begin
            calm_left--;
         end else begin
            calm_left = $urandom_range(0, 30);
            hold_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end
      end
   end

   task automatic add_request(input op_type op, input logic [63:0] addr,
                              input logic [63:0] size);
      req_type r;
      r.operation        = op;
      r.physical_address = addr;
      r.size_bytes       = size;
      request_backlog.push_back(r);
   endtask

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // request covering the given number of pages from a page, random offset
   task automatic add_span(input logic [51:0] page, input int pages);
      int pick;
      int offs;
      int lo;
      int hi;
      pick = $urandom_range(0, 7);
      offs = (pick == 0) ? 0 : (pick == 1) ? 4095 : $urandom_range(0, 4095);
      hi   = pages * 4096 - offs;
      lo   = (pages - 1) * 4096 - offs + 1;
      if (lo < 1) lo = 1;
      add_request(OP_RESERVE, {page, 12'(offs)},
                  (pick < 2) ? 64'(hi) : 64'($urandom_range(hi, lo)));
   endtask

   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] RUN_ADDR = 64'h0000_7A5C_3000_0000;
   localparam logic [63:0] PAGE     = 64'h1000;

   initial begin
      logic [63:0] raw;
      logic [51:0] base;
      logic [52:0] page_pick;
      int          episode_len;
      int          shape;
      int          pages;

      add_request(OP_CLEAR, 64'd0, 64'd0);
      add_request(OP_RESERVE, 64'd0, 64'd0);
      add_request(OP_RESERVE, ALL_ONES, 64'd1);
      add_request(OP_CLEAR, ALL_ONES, ALL_ONES);
      add_request(OP_RESERVE, ALL_ONES, 64'd2);
      add_request(OP_RESERVE, 64'd1, ALL_ONES);
      add_request(OP_RESERVE, 64'd0, ALL_ONES);
      add_request(OP_RESERVE, 64'd0, 17 * PAGE);
      add_request(OP_RESERVE, 64'd0, 16 * PAGE);
      add_request(OP_RESERVE, 64'h10, 64'd1);
      add_request(OP_RESERVE, 15 * PAGE + 5, PAGE);
      add_request(OP_RESERVE, 20 * PAGE, 64'd1);
      add_request(OP_CLEAR, 64'd0, 64'd0);
      add_request(OP_RESERVE, RUN_ADDR, 3 * PAGE);
      add_request(OP_RESERVE, RUN_ADDR + 64'h123, 5 * PAGE - 64'h123);
      add_request(OP_RESERVE, RUN_ADDR + PAGE, 2 * PAGE);
      add_request(OP_RESERVE, 64'h0000_0123_4560_0000, 14 * PAGE);
      add_request(OP_RESERVE, RUN_ADDR + 4 * PAGE, 3 * PAGE);
      add_request(OP_RESERVE, RUN_ADDR + 2 * PAGE + 64'h800, PAGE);
      add_request(OP_CLEAR, 64'h5555_AAAA_5555_AAAA, 64'hAAAA_5555_AAAA_5555);
      add_request(OP_RESERVE, 64'hFFF, 64'd1);

      while (request_backlog.size() < RANDOM_ITEMS + 22) begin
         if ($urandom_range(0, 3) != 0) add_request(OP_CLEAR, random_word(), random_word());
         if ($urandom_range(0, 7) == 0) begin
            base = 52'hF_FFFF_FFFF_FFFF - 52'($urandom_range(0, 10));
         end else begin
            raw  = random_word();
            base = raw[51:0];
         end
         episode_len = $urandom_range(4, 20);
         repeat (episode_len) begin
            if ($urandom_range(0, 99) < 85) begin
               page_pick = {1'b0, base} + 53'($urandom_range(0, 12));
               shape     = $urandom_range(0, 19);
               pages     = (shape < 13) ? $urandom_range(1, 4) :
                           (shape < 19) ? $urandom_range(5, 16) : 17;
               add_span(page_pick[52] ? 52'hF_FFFF_FFFF_FFFF : page_pick[51:0], pages);
            end else begin
               case ($urandom_range(0, 4))
                  0: add_request(OP_RESERVE, random_word(), 64'd0);
                  1: add_request(OP_RESERVE, random_word(), random_word());
                  2: add_request(OP_RESERVE, random_word(), 64'($urandom_range(1, 65536)));
                  3: add_request(OP_CLEAR, random_word(), random_word());
                  default: add_request(OP_RESERVE, ALL_ONES - 64'($urandom_range(0, 8192)),
                                       64'($urandom_range(1, 16384)));
               endcase
            end
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (request_backlog.size() != 0 || req_valid || pending_grants.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);

      if (error_count == 0) begin
         $display("[page_window_slot_reserver_unit] OK");
      end else begin
         $display("[page_window_slot_reserver_unit] ERROR");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("[page_window_slot_reserver_unit] ERROR");
      $finish;
   end

endmodule

>>> files.f
src/pwsr_pkg.sv
src/pwsr_ram.sv
src/page_window_slot_reserver_unit.sv
sim/page_window_slot_reserver_unit_test.sv
